// ----- rtl/core/xmrx_pkg.sv -----
// Shared constants for the XMODEM-CRC/1K receiver: codes, control bytes and widths.
`timescale 1ns / 1ps

package xmrx_pkg;

  // Item operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_RETRIES = 2'd0;
  localparam logic [1:0] REG_HDR_WAIT     = 2'd1;
  localparam logic [1:0] REG_BYTE_WAIT    = 2'd2;

  // Register reset values
  localparam logic [7:0]  SYNC_RETRIES_RST = 8'd25;
  localparam logic [31:0] HDR_WAIT_RST     = 32'd50000000;
  localparam logic [31:0] BYTE_WAIT_RST    = 32'd10000000;

  // Link bytes
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  // CRC-16/XMODEM
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // Block lengths, held in the payload index width
  localparam int unsigned IDX_BITS = 11;
  localparam logic [IDX_BITS-1:0] LEN_SHORT = 11'd128;
  localparam logic [IDX_BITS-1:0] LEN_LONG  = 11'd1024;

  // Fixed port widths
  localparam int unsigned OUT_ADDR_BITS = 24;
  localparam int unsigned STATUS_BITS   = 3;

  // Status codes
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_SYNC_TO  = 3'd2;
  localparam logic [2:0] ST_BYTE_TO  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

endpackage

// ----- rtl/core/xmrx_crc_step.sv -----
// CRC-16/XMODEM update over one byte, MSB first.
`timescale 1ns / 1ps

module xmrx_crc_step (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import xmrx_pkg::*;

  logic [15:0] acc;

  always_comb begin
    acc = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((acc & CRC_MSB) != 16'h0000) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

// ----- rtl/core/xmodem_crc_1k_receiver_unit.sv -----
// Top level of the XMODEM-CRC/1K receiver: input register, protocol state, result register.
`timescale 1ns / 1ps

// XMODEM-CRC/1K receiver. Feed it start, received-byte and tick beats; every
// accepted beat yields exactly one result beat carrying an optional control
// byte to transmit ('C', ACK or NAK), an optional payload write, a commit flag,
// the session status and the accepted byte count. One beat is taken per clock
// cycle while the result side does not stall; a result is offered once its
// input beat has passed the input register (from which the protocol state
// and the byte-wide CRC update are evaluated) and then the result register.
// Stall on the result side propagates back to in_stall in the same cycle.
// Configuration writes are always ready and take effect on the next beat.
// ADDR_BITS sets the size of the destination space; payload beyond it is
// dropped and a block that would overrun it ends the session with overflow status.

module xmodem_crc_1k_receiver_unit #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_rx_byte,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_wr_valid,
  output logic [xmrx_pkg::OUT_ADDR_BITS-1:0] out_wr_addr,
  output logic [7:0]  out_wr_data,
  output logic        out_block_commit,
  output logic [xmrx_pkg::STATUS_BITS-1:0] out_status,
  output logic [xmrx_pkg::OUT_ADDR_BITS-1:0] out_received_count
);
  import xmrx_pkg::*;

  // count holds one extra bit so that a full space is told apart from empty
  localparam int unsigned TW = ADDR_BITS + 1;
  localparam logic [32:0] CAP = 33'(1) << ADDR_BITS;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SYNC    = 4'd1;
  localparam logic [3:0] PH_HDR     = 4'd2;
  localparam logic [3:0] PH_NUM     = 4'd3;
  localparam logic [3:0] PH_INV     = 4'd4;
  localparam logic [3:0] PH_DATA    = 4'd5;
  localparam logic [3:0] PH_CRCHI   = 4'd6;
  localparam logic [3:0] PH_CRCLO   = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;
  localparam logic [3:0] PH_SYNC_TO = 4'd9;
  localparam logic [3:0] PH_BYTE_TO = 4'd10;
  localparam logic [3:0] PH_OVF     = 4'd11;

  // configuration registers
  logic [7:0]  sync_retries_r;
  logic [31:0] hdr_wait_r;
  logic [31:0] byte_wait_r;

  // input register
  logic        in_valid_r;
  logic [1:0]  in_op_r;
  logic [7:0]  in_byte_r;

  // protocol state
  logic [3:0]          phase_r, phase_nxt;
  logic [7:0]          exp_blk_r, exp_blk_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [7:0]          retry_r, retry_nxt;
  logic [31:0]         timer_r, timer_nxt;
  logic [IDX_BITS-1:0] pidx_r, pidx_nxt;
  logic                long_r, long_nxt;
  logic [7:0]          blk_num_r, blk_num_nxt;
  logic [7:0]          blk_inv_r, blk_inv_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [7:0]          crc_hi_r, crc_hi_nxt;

  // result register
  logic        out_valid_r;
  logic        tx_valid_r, tx_valid_nxt;
  logic [7:0]  tx_byte_r, tx_byte_nxt;
  logic        wr_valid_r, wr_valid_nxt;
  logic [OUT_ADDR_BITS-1:0] wr_addr_r, wr_addr_nxt;
  logic [7:0]  wr_data_r, wr_data_nxt;
  logic        commit_r, commit_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic [OUT_ADDR_BITS-1:0] count_r, count_nxt;

  logic                adv;
  logic [15:0]         crc_upd;
  logic [IDX_BITS-1:0] blk_len;
  logic [IDX_BITS-1:0] pidx_inc;
  logic [31:0]         timer_inc;
  logic [31:0]         wait_lim;
  logic                expired;
  logic [32:0]         addr_sum;
  logic [32:0]         end_sum;
  logic [32:0]         total_ext;
  logic                block_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_retries_r <= SYNC_RETRIES_RST;
      hdr_wait_r     <= HDR_WAIT_RST;
      byte_wait_r    <= BYTE_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_RETRIES: sync_retries_r <= cfg_data[7:0];
        REG_HDR_WAIT:     hdr_wait_r     <= cfg_data;
        REG_BYTE_WAIT:    byte_wait_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage advances when the result register is free or being drained
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_op_r   <= in_operation;
      in_byte_r <= in_rx_byte;
    end
  end

  xmrx_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (in_byte_r),
    .crc_out (crc_upd)
  );

  assign blk_len   = long_r ? LEN_LONG : LEN_SHORT;
  assign pidx_inc  = pidx_r + IDX_BITS'(1);
  assign timer_inc = timer_r + 32'd1;
  assign wait_lim  = (phase_r == PH_SYNC || phase_r == PH_HDR) ? hdr_wait_r : byte_wait_r;
  assign expired   = timer_inc >= wait_lim;
  assign addr_sum  = 33'(total_r) + 33'(pidx_r);
  assign end_sum   = 33'(total_r) + 33'(blk_len);
  assign block_ok  = (blk_num_r == exp_blk_r) &&
                     ((blk_num_r + blk_inv_r) == BYTE_FF) &&
                     ({crc_hi_r, in_byte_r} == crc_r);

  always_comb begin
    phase_nxt    = phase_r;
    exp_blk_nxt  = exp_blk_r;
    total_nxt    = total_r;
    retry_nxt    = retry_r;
    timer_nxt    = timer_r;
    pidx_nxt     = pidx_r;
    long_nxt     = long_r;
    blk_num_nxt  = blk_num_r;
    blk_inv_nxt  = blk_inv_r;
    crc_nxt      = crc_r;
    crc_hi_nxt   = crc_hi_r;
    tx_valid_nxt = 1'b0;
    tx_byte_nxt  = 8'h00;
    wr_valid_nxt = 1'b0;
    wr_addr_nxt  = '0;
    wr_data_nxt  = 8'h00;
    commit_nxt   = 1'b0;

    case (in_op_r)
      OP_START: begin
        phase_nxt    = PH_SYNC;
        exp_blk_nxt  = 8'd1;
        total_nxt    = '0;
        retry_nxt    = 8'd1;
        timer_nxt    = 32'd0;
        pidx_nxt     = '0;
        tx_valid_nxt = 1'b1;
        tx_byte_nxt  = CH_C;
      end
      OP_TICK: begin
        if (phase_r == PH_SYNC) begin
          timer_nxt = timer_inc;
          if (expired) begin
            timer_nxt = 32'd0;
            if (retry_r >= sync_retries_r) begin
              phase_nxt = PH_SYNC_TO;
            end else begin
              retry_nxt    = retry_r + 8'd1;
              tx_valid_nxt = 1'b1;
              tx_byte_nxt  = CH_C;
            end
          end
        end else if (phase_r >= PH_HDR && phase_r <= PH_CRCLO) begin
          // header wait and in-block byte wait both end in byte timeout
          timer_nxt = timer_inc;
          if (expired) begin
            timer_nxt = 32'd0;
            phase_nxt = PH_BYTE_TO;
          end
        end
      end
      OP_BYTE: begin
        if (phase_r == PH_SYNC || phase_r == PH_HDR) begin
          timer_nxt = 32'd0;
          if (in_byte_r == CH_EOT) begin
            tx_valid_nxt = 1'b1;
            tx_byte_nxt  = CH_ACK;
            phase_nxt    = PH_DONE;
          end else if (in_byte_r == CH_SOH || in_byte_r == CH_STX) begin
            long_nxt  = (in_byte_r == CH_STX);
            phase_nxt = PH_NUM;
          end else begin
            tx_valid_nxt = 1'b1;
            tx_byte_nxt  = CH_NAK;
            phase_nxt    = PH_HDR;
          end
        end else if (phase_r >= PH_NUM && phase_r <= PH_CRCLO) begin
          timer_nxt = 32'd0;
          case (phase_r)
            PH_NUM: begin
              blk_num_nxt = in_byte_r;
              phase_nxt   = PH_INV;
            end
            PH_INV: begin
              blk_inv_nxt = in_byte_r;
              pidx_nxt    = '0;
              crc_nxt     = 16'h0000;
              phase_nxt   = PH_DATA;
            end
            PH_DATA: begin
              crc_nxt = crc_upd;
              if (addr_sum < CAP) begin
                wr_valid_nxt = 1'b1;
                wr_addr_nxt  = addr_sum[OUT_ADDR_BITS-1:0];
                wr_data_nxt  = in_byte_r;
              end
              pidx_nxt = pidx_inc;
              if (pidx_inc >= blk_len) begin
                phase_nxt = PH_CRCHI;
              end
            end
            PH_CRCHI: begin
              crc_hi_nxt = in_byte_r;
              phase_nxt  = PH_CRCLO;
            end
            default: begin
              phase_nxt = PH_HDR;
              if (block_ok) begin
                if (end_sum > CAP) begin
                  phase_nxt = PH_OVF;
                end else begin
                  total_nxt    = total_r + TW'(blk_len);
                  exp_blk_nxt  = exp_blk_r + 8'd1;
                  commit_nxt   = 1'b1;
                  tx_valid_nxt = 1'b1;
                  tx_byte_nxt  = CH_ACK;
                end
              end else begin
                tx_valid_nxt = 1'b1;
                tx_byte_nxt  = CH_NAK;
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    case (phase_nxt)
      PH_DONE:    status_nxt = ST_COMPLETE;
      PH_SYNC_TO: status_nxt = ST_SYNC_TO;
      PH_BYTE_TO: status_nxt = ST_BYTE_TO;
      PH_OVF:     status_nxt = ST_OVERFLOW;
      default:    status_nxt = ST_BUSY;
    endcase

    total_ext = 33'(total_nxt);
    count_nxt = total_ext[OUT_ADDR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      exp_blk_r <= 8'd1;
      total_r   <= '0;
      retry_r   <= 8'd0;
      timer_r   <= 32'd0;
      pidx_r    <= '0;
      long_r    <= 1'b0;
      blk_num_r <= 8'd0;
      blk_inv_r <= 8'd0;
      crc_r     <= 16'h0000;
      crc_hi_r  <= 8'd0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      exp_blk_r <= exp_blk_nxt;
      total_r   <= total_nxt;
      retry_r   <= retry_nxt;
      timer_r   <= timer_nxt;
      pidx_r    <= pidx_nxt;
      long_r    <= long_nxt;
      blk_num_r <= blk_num_nxt;
      blk_inv_r <= blk_inv_nxt;
      crc_r     <= crc_nxt;
      crc_hi_r  <= crc_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
      wr_valid_r <= wr_valid_nxt;
      wr_addr_r  <= wr_addr_nxt;
      wr_data_r  <= wr_data_nxt;
      commit_r   <= commit_nxt;
      status_r   <= status_nxt;
      count_r    <= count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_valid       = tx_valid_r;
  assign out_tx_byte        = tx_byte_r;
  assign out_wr_valid       = wr_valid_r;
  assign out_wr_addr        = wr_addr_r;
  assign out_wr_data        = wr_data_r;
  assign out_block_commit   = commit_r;
  assign out_status         = status_r;
  assign out_received_count = count_r;

`ifndef NO_ASSERTIONS
  // a commit is always answered with ACK
  a_commit_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_commit) |-> (out_tx_valid && out_tx_byte == CH_ACK))
    else $error("commit without ACK");

  // a payload write never coincides with a control byte
  a_wr_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wr_valid) |-> !out_tx_valid)
    else $error("payload write with control byte");

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without result back-pressure");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
